// ----- design/bvd_pkg.sv -----
package bvd_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int PTR_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int EXT_W       = 64;

    localparam int CMD_W       = 3;
    localparam int DATA_W      = 32;
    localparam int POS_W       = 4;
    localparam int OCC_W       = 5;
    localparam int STAT_W      = 2;
    localparam int S_TDATA_W   = 32;
    localparam int S_TUSER_W   = 3;
    localparam int M_TDATA_W   = 48;
    localparam int M_TUSER_W   = 2;
    localparam int FOUND_BIT   = DATA_W;
    localparam int POS_LSB     = DATA_W + 1;
    localparam int OCC_LSB     = POS_LSB + POS_W;
    localparam int M_PAD_W     = M_TDATA_W - (OCC_LSB + OCC_W);

    localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REM_FRONT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REM_BACK  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DELETE    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SEARCH    = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    localparam int PC_W = 4;

    localparam logic [PC_W-1:0] STEP_IDLE     = 4'd0;
    localparam logic [PC_W-1:0] STEP_INS_F    = 4'd1;
    localparam logic [PC_W-1:0] STEP_INS_B    = 4'd2;
    localparam logic [PC_W-1:0] STEP_REM_F    = 4'd3;
    localparam logic [PC_W-1:0] STEP_TAKE_F   = 4'd4;
    localparam logic [PC_W-1:0] STEP_REM_B    = 4'd5;
    localparam logic [PC_W-1:0] STEP_TAKE_B   = 4'd6;
    localparam logic [PC_W-1:0] STEP_EMPTY    = 4'd7;
    localparam logic [PC_W-1:0] STEP_SCAN_RD  = 4'd8;
    localparam logic [PC_W-1:0] STEP_SCAN_CMP = 4'd9;
    localparam logic [PC_W-1:0] STEP_SCAN_END = 4'd10;
    localparam logic [PC_W-1:0] STEP_SHIFT_RD = 4'd11;
    localparam logic [PC_W-1:0] STEP_SHIFT_WR = 4'd12;
    localparam logic [PC_W-1:0] STEP_DEL_END  = 4'd13;
    localparam logic [PC_W-1:0] STEP_EMIT     = 4'd15;

    localparam int ACT_W = 4;

    localparam logic [ACT_W-1:0] ACT_NONE       = 4'd0;
    localparam logic [ACT_W-1:0] ACT_INS_FRONT  = 4'd1;
    localparam logic [ACT_W-1:0] ACT_INS_BACK   = 4'd2;
    localparam logic [ACT_W-1:0] ACT_RD_FRONT   = 4'd3;
    localparam logic [ACT_W-1:0] ACT_TAKE_FRONT = 4'd4;
    localparam logic [ACT_W-1:0] ACT_RD_BACK    = 4'd5;
    localparam logic [ACT_W-1:0] ACT_TAKE_BACK  = 4'd6;
    localparam logic [ACT_W-1:0] ACT_SET_EMPTY  = 4'd7;
    localparam logic [ACT_W-1:0] ACT_RD_IDX     = 4'd8;
    localparam logic [ACT_W-1:0] ACT_CMP        = 4'd9;
    localparam logic [ACT_W-1:0] ACT_RD_NEXT    = 4'd10;
    localparam logic [ACT_W-1:0] ACT_SHIFT      = 4'd11;
    localparam logic [ACT_W-1:0] ACT_DEC_CNT    = 4'd12;
    localparam logic [ACT_W-1:0] ACT_EMIT       = 4'd13;

    localparam int COND_W = 4;

    localparam logic [COND_W-1:0] C_ALWAYS    = 4'd0;
    localparam logic [COND_W-1:0] C_DISPATCH  = 4'd1;
    localparam logic [COND_W-1:0] C_EMPTY     = 4'd2;
    localparam logic [COND_W-1:0] C_IDX_END   = 4'd3;
    localparam logic [COND_W-1:0] C_NOMATCH   = 4'd4;
    localparam logic [COND_W-1:0] C_IS_SEARCH = 4'd5;
    localparam logic [COND_W-1:0] C_LAST      = 4'd6;
    localparam logic [COND_W-1:0] C_OUT_BUSY  = 4'd7;

    typedef struct packed {
        logic [ACT_W-1:0]  act;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
    } t_ctrl;

    // When the condition holds the sequencer jumps to target, else it steps on.
    // The emit step sits at the top address so that stepping on wraps to idle.
    function automatic t_ctrl ctrl_rom(input logic [PC_W-1:0] pc);
        t_ctrl c;
        c = '{act: ACT_NONE, cond: C_ALWAYS, target: STEP_IDLE};
        case (pc)
            STEP_IDLE:     c = '{act: ACT_NONE,       cond: C_DISPATCH,  target: STEP_IDLE};
            STEP_INS_F:    c = '{act: ACT_INS_FRONT,  cond: C_ALWAYS,    target: STEP_EMIT};
            STEP_INS_B:    c = '{act: ACT_INS_BACK,   cond: C_ALWAYS,    target: STEP_EMIT};
            STEP_REM_F:    c = '{act: ACT_RD_FRONT,   cond: C_EMPTY,     target: STEP_EMPTY};
            STEP_TAKE_F:   c = '{act: ACT_TAKE_FRONT, cond: C_ALWAYS,    target: STEP_EMIT};
            STEP_REM_B:    c = '{act: ACT_RD_BACK,    cond: C_EMPTY,     target: STEP_EMPTY};
            STEP_TAKE_B:   c = '{act: ACT_TAKE_BACK,  cond: C_ALWAYS,    target: STEP_EMIT};
            STEP_EMPTY:    c = '{act: ACT_SET_EMPTY,  cond: C_ALWAYS,    target: STEP_EMIT};
            STEP_SCAN_RD:  c = '{act: ACT_RD_IDX,     cond: C_IDX_END,   target: STEP_EMIT};
            STEP_SCAN_CMP: c = '{act: ACT_CMP,        cond: C_NOMATCH,   target: STEP_SCAN_RD};
            STEP_SCAN_END: c = '{act: ACT_NONE,       cond: C_IS_SEARCH, target: STEP_EMIT};
            STEP_SHIFT_RD: c = '{act: ACT_RD_NEXT,    cond: C_LAST,      target: STEP_DEL_END};
            STEP_SHIFT_WR: c = '{act: ACT_SHIFT,      cond: C_ALWAYS,    target: STEP_SHIFT_RD};
            STEP_DEL_END:  c = '{act: ACT_DEC_CNT,    cond: C_ALWAYS,    target: STEP_EMIT};
            STEP_EMIT:     c = '{act: ACT_EMIT,       cond: C_OUT_BUSY,  target: STEP_EMIT};
            default:       c = '{act: ACT_NONE,       cond: C_ALWAYS,    target: STEP_IDLE};
        endcase
        return c;
    endfunction

    function automatic logic [PC_W-1:0] dispatch(input logic [CMD_W-1:0] cmd);
        logic [PC_W-1:0] pc;
        case (cmd)
            CMD_INS_FRONT: pc = STEP_INS_F;
            CMD_INS_BACK:  pc = STEP_INS_B;
            CMD_REM_FRONT: pc = STEP_REM_F;
            CMD_REM_BACK:  pc = STEP_REM_B;
            CMD_DELETE:    pc = STEP_SCAN_RD;
            CMD_SEARCH:    pc = STEP_SCAN_RD;
            default:       pc = STEP_EMIT;
        endcase
        return pc;
    endfunction

endpackage

// ----- design/bvd_ram.sv -----
module bvd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/bounded_value_deque_with_delete_core.sv -----
// Bounded deque of signed values with delete-by-value and search.
// Commands arrive on the s_axis channel: tuser carries the command code and
// tdata the value. Each command yields exactly one result transaction on the
// m_axis channel: tdata holds the removed value, the found flag, the position
// and the occupancy; tuser holds the status.
// A small microprogram steps a datapath around one store that has a separate
// write port and a registered read port. Unused codes go straight to the emit
// step; inserts write the store directly; removals read the front or back
// element and then take it, or report empty; a search reads and compares each
// element in turn; a delete scans for its match, then shifts each later element down.
// Every scanned or shifted element needs a read step and then a compare or
// write step because the store read is registered. The next command is taken
// in the cycle after its result is loaded, one command at a time.
// The result sits in an output register; while the receiver stalls, the
// block holds in its emit step and accepts no new command.
// Reset empties the deque and clears the output valid; the store contents
// are not cleared and need no clearing pass.
module bounded_value_deque_with_delete_core import bvd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // item_value
    input  logic [S_TUSER_W-1:0] s_axis_tuser,  // cmd
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // removed_value, found, position, occupancy
    output logic [M_TUSER_W-1:0] m_axis_tuser   // status
);

    logic [PC_W-1:0]        r_pc;
    logic [PC_W-1:0]        n_pc;
    t_ctrl                  w_ctrl;
    logic                   w_cond;

    logic [CMD_W-1:0]       r_cmd;
    logic [VALUE_WIDTH-1:0] r_value;
    logic [PTR_W-1:0]       r_fp;
    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       r_idx;
    logic [DATA_W-1:0]      r_removed;
    logic                   r_found;
    logic [CNT_W-1:0]       r_pos;
    logic [STAT_W-1:0]      r_status;
    logic                   r_m_valid;
    logic [M_TDATA_W-1:0]   r_m_tdata;
    logic [M_TUSER_W-1:0]   r_m_tuser;

    logic                   w_accept;
    logic                   w_full;
    logic                   w_empty;
    logic                   w_match;
    logic                   w_last;
    logic                   w_out_free;
    logic [CNT_W-1:0]       w_idx_next;
    logic [PTR_W-1:0]       w_fp_dec;
    logic [EXT_W-1:0]       w_in_ext;
    logic [EXT_W-1:0]       w_rd_ext;
    logic [VALUE_WIDTH-1:0] w_in_value;

    logic                   w_we;
    logic [PTR_W-1:0]       w_waddr;
    logic [VALUE_WIDTH-1:0] w_wdata;
    logic [PTR_W-1:0]       w_raddr;
    logic [VALUE_WIDTH-1:0] w_rdata;

    function automatic logic [PTR_W-1:0] slot(input logic [PTR_W-1:0] base,
                                              input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(DEPTH)) begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    assign w_ctrl        = ctrl_rom(r_pc);
    assign s_axis_tready = (r_pc == STEP_IDLE);
    assign w_accept      = s_axis_tvalid & s_axis_tready;
    assign w_full        = (r_cnt == CNT_W'(DEPTH));
    assign w_empty       = (r_cnt == '0);
    assign w_match       = (w_rdata == r_value);
    assign w_idx_next    = r_idx + CNT_W'(1);
    assign w_last        = (w_idx_next >= r_cnt);
    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign w_fp_dec      = (r_fp == '0) ? PTR_W'(DEPTH - 1) : r_fp - PTR_W'(1);
    assign w_in_ext      = EXT_W'(signed'(s_axis_tdata[DATA_W-1:0]));
    assign w_in_value    = w_in_ext[VALUE_WIDTH-1:0];
    assign w_rd_ext      = EXT_W'(signed'(w_rdata));

    always_comb begin
        w_cond = 1'b0;
        case (w_ctrl.cond)
            C_ALWAYS:    w_cond = 1'b1;
            C_EMPTY:     w_cond = w_empty;
            C_IDX_END:   w_cond = (r_idx == r_cnt);
            C_NOMATCH:   w_cond = !w_match;
            C_IS_SEARCH: w_cond = (r_cmd == CMD_SEARCH);
            C_LAST:      w_cond = w_last;
            C_OUT_BUSY:  w_cond = !w_out_free;
            default:     w_cond = 1'b0;
        endcase
        n_pc = w_cond ? w_ctrl.target : r_pc + PC_W'(1);
        if (w_ctrl.cond == C_DISPATCH) begin
            n_pc = w_accept ? dispatch(s_axis_tuser) : r_pc;
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = slot(r_fp, r_idx);
        w_wdata = r_value;
        w_raddr = slot(r_fp, r_idx);
        case (w_ctrl.act)
            ACT_INS_FRONT: begin
                w_we    = !w_full;
                w_waddr = w_fp_dec;
            end
            ACT_INS_BACK: begin
                w_we    = !w_full;
                w_waddr = slot(r_fp, r_cnt);
            end
            ACT_RD_FRONT: w_raddr = r_fp;
            ACT_RD_BACK:  w_raddr = slot(r_fp, r_cnt - CNT_W'(1));
            ACT_RD_NEXT:  w_raddr = slot(r_fp, w_idx_next);
            ACT_SHIFT: begin
                w_we    = 1'b1;
                w_wdata = w_rdata;
            end
            default: ;
        endcase
    end

    bvd_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= STEP_IDLE;
            r_fp      <= '0;
            r_cnt     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (w_ctrl.act == ACT_EMIT && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (w_ctrl.act)
                ACT_INS_FRONT: begin
                    if (!w_full) begin
                        r_fp  <= w_fp_dec;
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                ACT_INS_BACK: begin
                    if (!w_full) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                ACT_TAKE_FRONT: begin
                    r_fp  <= slot(r_fp, CNT_W'(1));
                    r_cnt <= r_cnt - CNT_W'(1);
                end
                ACT_TAKE_BACK: r_cnt <= r_cnt - CNT_W'(1);
                ACT_DEC_CNT:   r_cnt <= r_cnt - CNT_W'(1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd     <= s_axis_tuser;
            r_value   <= w_in_value;
            r_idx     <= '0;
            r_removed <= '0;
            r_found   <= 1'b0;
            r_pos     <= '0;
            r_status  <= ST_OK;
        end
        case (w_ctrl.act)
            ACT_INS_FRONT, ACT_INS_BACK: begin
                if (w_full) begin
                    r_status <= ST_FULL;
                end
            end
            ACT_TAKE_FRONT, ACT_TAKE_BACK: r_removed <= w_rd_ext[DATA_W-1:0];
            ACT_SET_EMPTY: r_status <= ST_EMPTY;
            ACT_CMP: begin
                if (w_match) begin
                    r_found <= 1'b1;
                    r_pos   <= r_idx;
                end else begin
                    r_idx <= w_idx_next;
                end
            end
            ACT_SHIFT: r_idx <= w_idx_next;
            ACT_EMIT: begin
                if (w_out_free) begin
                    r_m_tdata <= {{M_PAD_W{1'b0}}, OCC_W'(r_cnt), POS_W'(r_pos),
                                  r_found, r_removed};
                    r_m_tuser <= r_status;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

endmodule

// ----- design/bvd_checker.sv -----
module bvd_checker import bvd_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] i_m_tdata,
    input logic [M_TUSER_W-1:0] i_m_tuser
);

    logic [DATA_W-1:0] w_removed;
    logic              w_found;
    logic [POS_W-1:0]  w_pos;
    logic [OCC_W-1:0]  w_occ;

    assign w_removed = i_m_tdata[DATA_W-1:0];
    assign w_found   = i_m_tdata[FOUND_BIT];
    assign w_pos     = i_m_tdata[POS_LSB +: POS_W];
    assign w_occ     = i_m_tdata[OCC_LSB +: OCC_W];

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))
        else $error("stalled result changed");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser == ST_FULL |-> w_occ == OCC_W'(DEPTH) && !w_found)
        else $error("full status with room left");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser == ST_EMPTY |-> w_occ == '0 && w_removed == '0 && !w_found)
        else $error("empty status with elements or data");

    a_pos_needs_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !w_found |-> w_pos == '0)
        else $error("position reported without a match");

endmodule

bind bounded_value_deque_with_delete_core bvd_checker u_bvd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);

// ----- tb/deque_result_checker.sv -----
`timescale 1ns / 100ps

module deque_result_checker import bvd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    input  logic                 i_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,   // item_value
    input  logic [S_TUSER_W-1:0] i_s_axis_tuser,   // cmd
    input  logic                 i_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    input  logic [M_TDATA_W-1:0] i_m_axis_tdata,   // removed_value, found, position, occupancy
    input  logic [M_TUSER_W-1:0] i_m_axis_tuser,   // status
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic [DATA_W-1:0] removed;
        logic              found;
        logic [POS_W-1:0]  position;
        logic [OCC_W-1:0]  occupancy;
        logic [STAT_W-1:0] status;
    } t_deque_result;

    logic [VALUE_WIDTH-1:0] ring [DEPTH];
    int unsigned            head;
    int unsigned            fill;
    t_deque_result          expected_results [$];

    function automatic int unsigned ring_slot(input int unsigned offset);
        return (head + offset) % DEPTH;
    endfunction

    function automatic t_deque_result apply_deque_command(input logic [CMD_W-1:0] cmd,
                                                          input logic [DATA_W-1:0] raw);
        t_deque_result          r;
        logic [VALUE_WIDTH-1:0] v;
        int                     hit;
        r   = '0;
        v   = VALUE_WIDTH'($signed(raw));
        hit = -1;
        if (cmd == CMD_DELETE || cmd == CMD_SEARCH) begin
            for (int i = 0; i < int'(fill); i++) begin
                if (hit < 0 && ring[ring_slot(i)] == v) begin
                    hit = i;
                end
            end
        end
        case (cmd)
            CMD_INS_FRONT, CMD_INS_BACK: begin
                if (fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else if (cmd == CMD_INS_FRONT) begin
                    head       = (head + DEPTH - 1) % DEPTH;
                    ring[head] = v;
                    fill++;
                end else begin
                    ring[ring_slot(fill)] = v;
                    fill++;
                end
            end
            CMD_REM_FRONT: begin
                if (fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.removed = DATA_W'($signed(ring[head]));
                    head      = ring_slot(1);
                    fill--;
                end
            end
            CMD_REM_BACK: begin
                if (fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.removed = DATA_W'($signed(ring[ring_slot(fill - 1)]));
                    fill--;
                end
            end
            CMD_DELETE: begin
                if (hit >= 0) begin
                    r.found    = 1'b1;
                    r.position = POS_W'(hit);
                    for (int i = hit; i + 1 < int'(fill); i++) begin
                        ring[ring_slot(i)] = ring[ring_slot(i + 1)];
                    end
                    fill--;
                end
            end
            CMD_SEARCH: begin
                if (hit >= 0) begin
                    r.found    = 1'b1;
                    r.position = POS_W'(hit);
                end
            end
            default: begin
            end
        endcase
        r.occupancy = OCC_W'(fill);
        return r;
    endfunction

    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            o_fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_deque_result want;
        if (!i_rst_n) begin
            head = 0;
            fill = 0;
            expected_results.delete();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                expected_results.push_back(
                    apply_deque_command(i_s_axis_tuser[CMD_W-1:0], i_s_axis_tdata[DATA_W-1:0]));
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result transaction, expected none, actual %0h/%0h",
                             $time, i_m_axis_tdata, i_m_axis_tuser);
                end else begin
                    want = expected_results.pop_front();
                    compare_field("removed_value", 64'(want.removed),
                                  64'(i_m_axis_tdata[DATA_W-1:0]));
                    compare_field("found", 64'(want.found), 64'(i_m_axis_tdata[FOUND_BIT]));
                    compare_field("position", 64'(want.position),
                                  64'(i_m_axis_tdata[POS_LSB +: POS_W]));
                    compare_field("occupancy", 64'(want.occupancy),
                                  64'(i_m_axis_tdata[OCC_LSB +: OCC_W]));
                    compare_field("status", 64'(want.status),
                                  64'(i_m_axis_tuser[STAT_W-1:0]));
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import bvd_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
    localparam int RANDOM_ITEMS = 1324;
    localparam int HOLD_CYCLES  = 400;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // item_value
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;   // cmd
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;        // removed_value, found, position, occupancy
    logic [M_TUSER_W-1:0] m_axis_tuser;        // status

    int   fail_count;
    int   pending_count;
    bit   calm = 1'b0;
    bit   hold_request = 1'b0;

    logic [DATA_W-1:0] value_pool [$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    bounded_value_deque_with_delete_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    deque_result_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tuser  (m_axis_tuser),
        .o_fail_count    (fail_count),
        .o_pending       (pending_count)
    );

    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value);
        while (!calm && $urandom_range(99) < 25) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= S_TUSER_W'(cmd);
        s_axis_tdata  <= S_TDATA_W'(value);
        do @(posedge i_clk); while (!s_axis_tready);
        if (cmd == CMD_INS_FRONT || cmd == CMD_INS_BACK) begin
            value_pool.push_back(value);
            if (value_pool.size() > 24) begin
                void'(value_pool.pop_front());
            end
        end
    endtask

    task automatic drain_results();
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    initial begin
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_request = 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(99) >= 25);
            end
        end
    end

    initial begin
        logic [DATA_W-1:0] value;
        logic [CMD_W-1:0]  cmd;
        int                phase;
        int                roll;
        int                ins_weight;
        int                rem_weight;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_command(CMD_REM_FRONT, '0);
        send_command(CMD_REM_BACK, '0);
        send_command(CMD_SEARCH, '0);
        send_command(CMD_DELETE, '0);
        send_command(CMD_SPARE_6, 32'hFFFF_FFFF);
        send_command(CMD_SPARE_7, 32'h5A5A_A5A5);
        send_command(CMD_INS_FRONT, 32'h7FFF_FFFF);
        send_command(CMD_INS_BACK, 32'h8000_0000);
        send_command(CMD_INS_FRONT, 32'hFFFF_FFFF);
        send_command(CMD_INS_BACK, 32'h0000_0000);
        for (int k = 1; k <= 12; k++) begin
            send_command(CMD_INS_BACK, DATA_W'(k));
        end
        send_command(CMD_INS_FRONT, 32'h1234_5678);
        send_command(CMD_INS_BACK, 32'h1234_5678);
        send_command(CMD_SEARCH, DATA_W'(12));
        send_command(CMD_DELETE, 32'hFFFF_FFFF);
        s_axis_tvalid <= 1'b0;
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 500 && n < 700);
            if (n == 900) begin
                hold_request = 1'b1;
            end
            if (n == 1100) begin
                s_axis_tvalid <= 1'b0;
                drain_results();
            end

            phase      = (n / 64) % 4;
            ins_weight = (phase == 0) ? 60 : (phase == 2) ? 15 : 30;
            rem_weight = (phase == 2) ? 60 : (phase == 0) ? 15 : 20;
            roll       = $urandom_range(99);
            if (roll < ins_weight) begin
                cmd = roll[0] ? CMD_INS_BACK : CMD_INS_FRONT;
            end else if (roll < ins_weight + rem_weight) begin
                cmd = roll[0] ? CMD_REM_BACK : CMD_REM_FRONT;
            end else if (roll < 95) begin
                cmd = roll[0] ? CMD_SEARCH : CMD_DELETE;
            end else begin
                cmd = roll[0] ? CMD_SPARE_7 : CMD_SPARE_6;
            end

            roll = $urandom_range(99);
            if (roll < 45 && value_pool.size() > 0) begin
                value = value_pool[$urandom_range(value_pool.size() - 1)];
            end else if (roll < 70) begin
                value = DATA_W'($urandom_range(7));
            end else if (roll < 80) begin
                case ($urandom_range(4))
                    0:       value = 32'h0000_0000;
                    1:       value = 32'h7FFF_FFFF;
                    2:       value = 32'h8000_0000;
                    3:       value = 32'hFFFF_FFFF;
                    default: value = 32'h0000_0001;
                endcase
            end else begin
                value = $urandom;
            end

            send_command(cmd, value);
        end
        s_axis_tvalid <= 1'b0;
        calm = 1'b0;
        drain_results();
        repeat (80) @(posedge i_clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
